FILE: rtl/core/unix_seconds_to_calendar_defines.svh
// Assertion macros for the seconds-to-calendar converter.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef UNIX_SECONDS_TO_CALENDAR_DEFINES_SVH
`define UNIX_SECONDS_TO_CALENDAR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define US2CAL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define US2CAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/us2cal_pkg.sv
// Constants, field widths and the month length table for the calendar converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package us2cal_pkg;

    localparam logic [31:0] EPOCH_2000_SECONDS = 32'd946684800;
    localparam logic [31:0] SPAN_SECONDS       = 32'd3155760000;
    localparam logic [31:0] DIV_SEC            = 32'd60;
    localparam logic [31:0] DIV_MIN            = 32'd60;
    localparam logic [31:0] DIV_HOUR           = 32'd24;
    localparam logic [31:0] DIV_WEEK           = 32'd7;
    localparam logic [15:0] DAYS_QUAD          = 16'd1461;
    localparam logic [15:0] DAYS_YEAR          = 16'd365;
    localparam logic [15:0] DAYS_LEAP_YEAR     = 16'd366;
    localparam logic [3:0]  MONTH_FEB          = 4'd2;
    localparam logic [3:0]  MONTH_APR          = 4'd4;
    localparam logic [3:0]  MONTH_JUN          = 4'd6;
    localparam logic [3:0]  MONTH_SEP          = 4'd9;
    localparam logic [3:0]  MONTH_NOV          = 4'd11;
    localparam logic [3:0]  MONTH_DEC          = 4'd12;
    localparam logic [3:0]  MONTH_JAN          = 4'd1;
    localparam logic [2:0]  WEEKDAY_SAT        = 3'd6;
    localparam int          OUT_DATA_W         = 40;

    typedef struct packed {
        logic [2:0] weekday;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year_offset;
    } cal_fields_t;

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default:                                     len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/unix_seconds_to_calendar.sv
// Usage: seconds since 1970 in on s_*, calendar date and time for 2000..2099 out on m_*.
// One beat on s_tdata (32-bit count) gives one beat on m_tdata; m_tuser is out_of_range.
// From accept to m_tvalid the sequencer runs the shared subtractor through, in order:
// epoch rebase, range check, 32 steps each for /60, /60, /24, 16 steps for the weekday
// mod 7, 1 to 25 four-year steps, 1 to 4 year steps, 1 to 12 month steps, then the
// load of the output register. An input before 2000 goes from the epoch rebase, one
// after 2099 from the range check, straight to that load.
// s_tready is high only while the sequencer idles, so one beat is in flight at a time;
// the next beat is accepted only once the result is loaded.
// The finished beat sits in the output register; s_tready returns as soon as it is
// loaded, so a new beat is converted while the receiver stalls, and the sequencer
// waits before loading only if the earlier result is still untaken.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops m_tvalid.
// An out-of-range input gives zero calendar fields with m_tuser high.
// Depends on us2cal_pkg and unix_seconds_to_calendar_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "unix_seconds_to_calendar_defines.svh"

module unix_seconds_to_calendar
    import us2cal_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // [31:0] unix_seconds
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [6:0] year_offset, [10:7] month,
                                                  // [15:11] day, [20:16] hour,
                                                  // [26:21] minute, [32:27] second,
                                                  // [35:33] weekday, [39:36] zero
    output logic                       m_tuser    // [0] out_of_range
);

    typedef enum logic [3:0] {
        S_IDLE, S_RANGE, S_SPAN, S_DIV_SEC, S_DIV_MIN, S_DIV_HOUR, S_DIV_WEEK,
        S_QUAD, S_YEAR, S_MONTH, S_DONE
    } state_t;

    state_t      state_reg,   state_next;
    logic [31:0] work_reg,    work_next;
    logic [5:0]  rem_reg,     rem_next;
    logic [4:0]  cnt_reg,     cnt_next;
    logic [15:0] days_reg,    days_next;
    logic [6:0]  year_reg,    year_next;
    logic [3:0]  month_reg,   month_next;
    logic [5:0]  second_reg,  second_next;
    logic [5:0]  minute_reg,  minute_next;
    logic [4:0]  hour_reg,    hour_next;
    logic [2:0]  weekday_reg, weekday_next;
    logic        oor_reg,     oor_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    logic [31:0] sub_a, sub_b;
    logic [32:0] sub_diff;
    logic        sub_borrow;
    logic        div_state;
    logic [6:0]  trial;
    logic        leap;
    cal_fields_t fields;

    assign div_state = (state_reg == S_DIV_SEC) || (state_reg == S_DIV_MIN) ||
                       (state_reg == S_DIV_HOUR) || (state_reg == S_DIV_WEEK);
    assign trial     = {rem_reg, work_reg[31]};
    assign leap      = (year_reg[1:0] == 2'd0);

    // shared subtract and compare unit
    always_comb
    begin
        sub_a = {16'd0, days_reg};
        sub_b = 32'd0;
        unique case (state_reg)
            S_RANGE:
            begin
                sub_a = work_reg;
                sub_b = EPOCH_2000_SECONDS;
            end
            S_SPAN:
            begin
                sub_a = work_reg;
                sub_b = SPAN_SECONDS;
            end
            S_DIV_SEC:
            begin
                sub_a = {25'd0, trial};
                sub_b = DIV_SEC;
            end
            S_DIV_MIN:
            begin
                sub_a = {25'd0, trial};
                sub_b = DIV_MIN;
            end
            S_DIV_HOUR:
            begin
                sub_a = {25'd0, trial};
                sub_b = DIV_HOUR;
            end
            S_DIV_WEEK:
            begin
                sub_a = {25'd0, trial};
                sub_b = DIV_WEEK;
            end
            S_QUAD:  sub_b = {16'd0, DAYS_QUAD};
            S_YEAR:  sub_b = {16'd0, leap ? DAYS_LEAP_YEAR : DAYS_YEAR};
            S_MONTH: sub_b = {27'd0, month_length(month_reg, leap)};
            default: sub_b = 32'd0;
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[32];

    always_comb
    begin
        fields.year_offset = year_reg;
        fields.month       = month_reg;
        fields.day         = days_reg[4:0] + 5'd1;
        fields.hour        = hour_reg;
        fields.minute      = minute_reg;
        fields.second      = second_reg;
        fields.weekday     = weekday_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        work_next     = work_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        days_next     = days_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        second_next   = second_reg;
        minute_next   = minute_reg;
        hour_next     = hour_reg;
        weekday_next  = weekday_reg;
        oor_next      = oor_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // one restoring division step
        if (div_state)
        begin
            rem_next  = sub_borrow ? trial[5:0] : sub_diff[5:0];
            work_next = {work_reg[30:0], !sub_borrow};
            cnt_next  = cnt_reg + 5'd1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    work_next  = s_tdata;
                    oor_next   = 1'b0;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (sub_borrow)
                begin
                    oor_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    work_next  = sub_diff[31:0];
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                rem_next = 6'd0;
                cnt_next = 5'd0;
                if (!sub_borrow)
                begin
                    oor_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV_SEC;
                end
            end
            S_DIV_SEC:
            begin
                if (cnt_reg == 5'd31)
                begin
                    second_next = rem_next;
                    rem_next    = 6'd0;
                    state_next  = S_DIV_MIN;
                end
            end
            S_DIV_MIN:
            begin
                if (cnt_reg == 5'd31)
                begin
                    minute_next = rem_next;
                    rem_next    = 6'd0;
                    state_next  = S_DIV_HOUR;
                end
            end
            S_DIV_HOUR:
            begin
                if (cnt_reg == 5'd31)
                begin
                    hour_next  = rem_next[4:0];
                    days_next  = work_next[15:0];
                    work_next  = {work_next[15:0], 16'd0};
                    rem_next   = 6'd0;
                    cnt_next   = 5'd16;
                    state_next = S_DIV_WEEK;
                end
            end
            S_DIV_WEEK:
            begin
                if (cnt_reg == 5'd31)
                begin
                    weekday_next = (rem_next[2:0] == 3'd0) ? WEEKDAY_SAT
                                                           : rem_next[2:0] - 3'd1;
                    year_next    = 7'd0;
                    state_next   = S_QUAD;
                end
            end
            S_QUAD:
            begin
                if (!sub_borrow)
                begin
                    days_next = sub_diff[15:0];
                    year_next = year_reg + 7'd4;
                end
                else
                begin
                    state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (!sub_borrow)
                begin
                    days_next = sub_diff[15:0];
                    year_next = year_reg + 7'd1;
                end
                else
                begin
                    month_next = MONTH_JAN;
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (!sub_borrow && (month_reg != MONTH_DEC))
                begin
                    days_next  = sub_diff[15:0];
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = oor_reg;
                    m_tdata_next  = oor_reg ? '0 : {4'd0, fields};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            work_reg     <= '0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
            days_reg     <= '0;
            year_reg     <= '0;
            month_reg    <= '0;
            second_reg   <= '0;
            minute_reg   <= '0;
            hour_reg     <= '0;
            weekday_reg  <= '0;
            oor_reg      <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            work_reg     <= work_next;
            rem_reg      <= rem_next;
            cnt_reg      <= cnt_next;
            days_reg     <= days_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            second_reg   <= second_next;
            minute_reg   <= minute_next;
            hour_reg     <= hour_next;
            weekday_reg  <= weekday_next;
            oor_reg      <= oor_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `US2CAL_ASSERT_SAME(a_oor_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0,
        "out-of-range beat carries nonzero calendar fields")
    `US2CAL_ASSERT_SAME(a_date_valid, clk, rst_n, m_tvalid && !m_tuser,
        (m_tdata[10:7] >= 4'd1) && (m_tdata[10:7] <= 4'd12) && (m_tdata[15:11] != 5'd0) &&
        (m_tdata[20:16] <= 5'd23) && (m_tdata[35:33] <= 3'd6) && (m_tdata[6:0] <= 7'd99),
        "in-range beat carries an impossible date")
    `US2CAL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "sequencer idle right after accepting a beat")
    `US2CAL_ASSERT_SAME(a_rem_bound, clk, rst_n, state_reg == S_DIV_HOUR, rem_reg < 6'd24,
        "division remainder exceeds divisor")

endmodule

`default_nettype wire
